@@ src/ffa_pkg.sv @@
// shared types and constants for the first-fit region bitmap allocator
// no dependencies; used by ffa_front, ffa_queue, ffa_back and the top level
package ffa_pkg;

   // region map geometry: 1024 regions kept as 64 words of 16 bits
   localparam int MAX_REGIONS = 1024;
   localparam int WORD_BITS   = 16;
   localparam int NUM_WORDS   = MAX_REGIONS / WORD_BITS;

   localparam logic [10:0] POOL_RESET = 11'd1024;
   localparam logic [10:0] POOL_MAX   = 11'd1024;

   // request kinds as seen on the input channel
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // classified operations handed from front to back
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_NOSPACE = 2'd2;
   localparam logic [1:0] OP_BADADDR = 2'd3;

   // result status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_NOSPACE = 2'd1;
   localparam logic [1:0] STAT_RANGE   = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [11:0] need;   // regions requested, at least one
      logic [9:0]  lo;     // first region to clear (free only)
      logic [9:0]  hi;     // last region to clear (free only)
      logic [10:0] limit;  // usable pool size in regions
   } cmd_type;

endpackage

@@ src/ffa_front.sv @@
// front end: pool size register and classification of incoming requests
// depends on ffa_pkg
module ffa_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_kind,
   input  logic [19:0]      req_page_count,
   input  logic [40:0]      req_free_address,
   input  logic             csr_valid,
   input  logic [10:0]      csr_data,
   output ffa_pkg::cmd_type cmd
);

   logic [10:0] pool_ff, pool_in;
   logic [10:0] limit;
   logic [20:0] page_sum;
   logic [11:0] need_raw, need;
   logic [18:0] slot;
   logic        bad_addr;
   logic [12:0] end_raw;
   logic [10:0] end_clip;

   assign pool_in = csr_valid ? csr_data : pool_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff <= ffa_pkg::POOL_RESET;
      end else begin
         pool_ff <= pool_in;
      end
   end

   assign limit    = (pool_ff > ffa_pkg::POOL_MAX) ? ffa_pkg::POOL_MAX : pool_ff;
   assign page_sum = {1'b0, req_page_count} + 21'd511;
   assign need_raw = page_sum[20:9];
   assign need     = (need_raw == 12'd0) ? 12'd1 : need_raw;

   // free: region index relative to the pool base at 1 TB
   assign slot     = req_free_address[39:21];
   assign bad_addr = !req_free_address[40] || (slot >= {8'd0, limit});
   assign end_raw  = {3'd0, slot[9:0]} + {1'b0, need};
   assign end_clip = (end_raw > {2'd0, limit}) ? limit : end_raw[10:0];

   always_comb begin
      cmd.need  = need;
      cmd.limit = limit;
      cmd.lo    = 10'd0;
      cmd.hi    = 10'd0;
      if (req_kind == ffa_pkg::KIND_ALLOC) begin
         cmd.op = (need > {1'b0, limit}) ? ffa_pkg::OP_NOSPACE : ffa_pkg::OP_ALLOC;
      end else begin
         cmd.op = bad_addr ? ffa_pkg::OP_BADADDR : ffa_pkg::OP_FREE;
         cmd.lo = slot[9:0];
         cmd.hi = 10'(end_clip - 11'd1);
      end
   end

endmodule

@@ src/ffa_queue.sv @@
// two-entry command queue between front and back
// depends on ffa_pkg
module ffa_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  ffa_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output ffa_pkg::cmd_type out_cmd
);

   ffa_pkg::cmd_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

@@ src/ffa_back.sv @@
// back end: region map memory, word-serial first-fit scan and range update
// depends on ffa_pkg
module ffa_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  ffa_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [40:0]      rsp_address,
   output logic [1:0]       rsp_status
);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_SCAN = 2'd1;
   localparam logic [1:0] B_UPD  = 2'd2;
   localparam logic [1:0] B_RESP = 2'd3;

   logic [1:0]       state_ff, state_in;
   ffa_pkg::cmd_type cmd_ff, cmd_in;
   logic [6:0]       next_ff, next_in;
   logic             dvalid_ff, dvalid_in;
   logic [5:0]       didx_ff, didx_in;
   logic [10:0]      carry_ff, carry_in;
   logic [9:0]       lo_ff, lo_in, hi_ff, hi_in;
   logic [40:0]      res_addr_ff, res_addr_in;
   logic [1:0]       res_stat_ff, res_stat_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [40:0]      rsp_addr_ff, rsp_addr_in;
   logic [1:0]       rsp_stat_ff, rsp_stat_in;

   // map memory; a word never written reads as all free
   logic [15:0] map_mem [ffa_pkg::NUM_WORDS];
   logic [63:0] valid_ff;
   logic [15:0] rd_data_ff;
   logic        rd_ok_ff;
   logic        rd_en, wr_en;
   logic [5:0]  rd_idx, wr_idx;
   logic [15:0] wr_data;

   logic [15:0] word;
   logic [10:0] run [16];
   logic [15:0] hit;
   logic        found;
   logic [3:0]  hit_pos;
   logic [9:0]  hit_gidx;
   logic [11:0] start_wide;
   logic [9:0]  start;
   logic        word_last;
   logic [15:0] lo_mask, hi_mask, upd_word;
   logic        is_alloc;
   logic        stop;

   assign word     = rd_ok_ff ? rd_data_ff : 16'd0;
   assign is_alloc = (cmd_ff.op == ffa_pkg::OP_ALLOC);

   // run length ending at each bit of the current word
   always_comb begin
      logic       has_used;
      logic [3:0] lu;
      logic [9:0] gidx;
      for (int j = 0; j < 16; j++) begin
         has_used = 1'b0;
         lu       = 4'd0;
         for (int k = 0; k < 16; k++) begin
            if (k <= j && word[k]) begin
               has_used = 1'b1;
               lu       = 4'(k);
            end
         end
         run[j] = has_used ? (11'(j) - {7'd0, lu}) : (carry_ff + 11'(j) + 11'd1);
         gidx   = {didx_ff, 4'(j)};
         hit[j] = !word[j] && ({1'b0, run[j]} >= cmd_ff.need)
                  && ({1'b0, gidx} < cmd_ff.limit);
      end
   end

   always_comb begin
      found   = 1'b0;
      hit_pos = 4'd0;
      for (int j = 15; j >= 0; j--) begin
         if (hit[j]) begin
            found   = 1'b1;
            hit_pos = 4'(j);
         end
      end
   end

   assign hit_gidx   = {didx_ff, hit_pos};
   assign start_wide = {2'd0, hit_gidx} + 12'd1 - cmd_ff.need;
   assign start      = start_wide[9:0];
   assign word_last  = ({1'b0, didx_ff, 4'd0} + 11'd16) >= cmd_ff.limit;

   // bit mask of the update range inside the current word
   assign lo_mask  = (didx_ff == lo_ff[9:4]) ? (16'hFFFF << lo_ff[3:0]) : 16'hFFFF;
   assign hi_mask  = (didx_ff == hi_ff[9:4]) ? (16'hFFFF >> (4'd15 - hi_ff[3:0]))
                                             : 16'hFFFF;
   assign upd_word = is_alloc ? (word | (lo_mask & hi_mask))
                              : (word & ~(lo_mask & hi_mask));

   assign cmd_ready = (state_ff == B_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      next_in      = next_ff;
      dvalid_in    = 1'b0;
      didx_in      = didx_ff;
      carry_in     = carry_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      res_addr_in  = res_addr_ff;
      res_stat_in  = res_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_stat_in  = rsp_stat_ff;
      rd_en        = 1'b0;
      rd_idx       = next_ff[5:0];
      wr_en        = 1'b0;
      wr_idx       = didx_ff;
      wr_data      = upd_word;
      stop         = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (cmd_valid) begin
               cmd_in      = cmd;
               res_addr_in = 41'd0;
               res_stat_in = ffa_pkg::STAT_OK;
               next_in     = 7'd0;
               carry_in    = 11'd0;
               case (cmd.op)
                  ffa_pkg::OP_ALLOC: begin
                     state_in = B_SCAN;
                  end
                  ffa_pkg::OP_FREE: begin
                     lo_in    = cmd.lo;
                     hi_in    = cmd.hi;
                     next_in  = {1'b0, cmd.lo[9:4]};
                     state_in = B_UPD;
                  end
                  ffa_pkg::OP_NOSPACE: begin
                     res_stat_in = ffa_pkg::STAT_NOSPACE;
                     state_in    = B_RESP;
                  end
                  default: begin
                     res_stat_in = ffa_pkg::STAT_RANGE;
                     state_in    = B_RESP;
                  end
               endcase
            end
         end
         B_SCAN: begin
            if (dvalid_ff) begin
               if (found) begin
                  lo_in       = start;
                  hi_in       = hit_gidx;
                  res_addr_in = {1'b1, 9'd0, start, 21'd0};
                  next_in     = {1'b0, start[9:4]};
                  state_in    = B_UPD;
                  stop        = 1'b1;
               end else if (word_last) begin
                  res_stat_in = ffa_pkg::STAT_NOSPACE;
                  state_in    = B_RESP;
                  stop        = 1'b1;
               end else begin
                  carry_in = run[15];
               end
            end
            if (!next_ff[6] && !stop) begin
               rd_en     = 1'b1;
               dvalid_in = 1'b1;
               didx_in   = next_ff[5:0];
               next_in   = next_ff + 7'd1;
            end
         end
         B_UPD: begin
            if (dvalid_ff) begin
               wr_en = 1'b1;
               if (didx_ff == hi_ff[9:4]) begin
                  state_in = B_RESP;
                  stop     = 1'b1;
               end
            end
            if ((next_ff <= {1'b0, hi_ff[9:4]}) && !stop) begin
               rd_en     = 1'b1;
               dvalid_in = 1'b1;
               didx_in   = next_ff[5:0];
               next_in   = next_ff + 7'd1;
            end
         end
         B_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = res_addr_ff;
               rsp_stat_in  = res_stat_ff;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         dvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= 64'd0;
      end else begin
         state_ff     <= state_in;
         dvalid_ff    <= dvalid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      next_ff     <= next_in;
      didx_ff     <= didx_in;
      carry_ff    <= carry_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      res_addr_ff <= res_addr_in;
      res_stat_ff <= res_stat_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= map_mem[rd_idx];
         rd_ok_ff   <= valid_ff[rd_idx];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_address = rsp_addr_ff;
   assign rsp_status  = rsp_stat_ff;

endmodule

@@ src/first_fit_region_bitmap_allocator_top.sv @@
// top level of the first-fit region bitmap allocator
// depends on ffa_pkg, ffa_front, ffa_queue and ffa_back
// req channel: one beat per request; tuser is the kind (0 allocate, 1 free),
//   tdata carries the page count and, for a free, the address to release
// rsp channel: exactly one beat per request, in request order; tdata is the
//   allocated base address (zero on failure and on every free), tuser the status
// csr channel: writes the pool size in 2 MB regions; ready is always high,
//   write only while no request is outstanding
// timing: the front classifies a request in the cycle it is taken and queues it
//   (two entries), so req stays ready while the back is busy until both are full
//   the back reads the 64-word region map one word per cycle through a single
//   read port: an allocate scans words until a fit and then marks the range,
//   a free clears its range, and a rejected request goes straight to the result;
//   the worst case is a full scan plus a full mark
// reset: the map comes up all free through per-word valid bits, no clearing pass;
//   pool size resets to 1024 regions
// stall: a finished result sits in the output register; the back waits there and
//   the queue absorbs up to two further requests before req drops
module first_fit_region_bitmap_allocator_top (
   input  logic        clock,
   input  logic        reset,
   // request beat
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [19:0] page_count, [60:20] free_address, rest zero
   input  logic [0:0]  req_tuser,   // [0] kind
   // result beat
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [40:0] region_address, rest zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // pool size register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_data     // pool_regions
);

   ffa_pkg::cmd_type front_cmd;
   ffa_pkg::cmd_type back_cmd;
   logic             q_in_ready;
   logic             q_out_valid;
   logic             q_out_ready;
   logic [40:0]      rsp_address;
   logic [1:0]       rsp_status;

   assign csr_ready  = 1'b1;
   assign req_tready = q_in_ready;

   // front: size rounding, pool bounds, early rejects
   ffa_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_kind         (req_tuser[0]),
      .req_page_count   (req_tdata[19:0]),
      .req_free_address (req_tdata[60:20]),
      .csr_valid        (csr_valid && csr_ready),
      .csr_data         (csr_data),
      .cmd              (front_cmd)
   );

   // decoupling queue
   ffa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (q_in_ready),
      .in_cmd    (front_cmd),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_cmd   (back_cmd)
   );

   // back: map scan and update, result register
   ffa_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (q_out_valid),
      .cmd_ready   (q_out_ready),
      .cmd         (back_cmd),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_address (rsp_address),
      .rsp_status  (rsp_status)
   );

   assign rsp_tdata = {7'd0, rsp_address};
   assign rsp_tuser = rsp_status;

`ifndef SYNTHESIS
   // results with an error status never carry an address
   a_addr_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ffa_pkg::STAT_OK) |-> (rsp_tdata == 48'd0))
      else $error("nonzero address with error status");

   // a granted address always lies in the pool above 1 TB
   a_addr_in_pool: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata != 48'd0) |-> (rsp_tdata[40] && rsp_tdata[39:31] == 9'd0
                                              && rsp_tdata[20:0] == 21'd0))
      else $error("allocated address outside pool or misaligned");

   // the back takes a command only when the queue offers one
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      (q_out_ready && !q_out_valid) |=> !rsp_tvalid || $stable(rsp_tdata) || $past(rsp_tready))
      else $error("result changed without a command");
`endif

endmodule
